### src/nswt_pkg.sv
// Package for the note sequencer wavetable tone block.
// Holds sizes, operation and register codes, and the port structs shared by its modules.
// No dependencies.
package nswt_pkg;

	localparam int NOTE_DEPTH    = 256;
	localparam int WAVE_DEPTH    = 64;
	localparam int DURATION_BITS = 28;
	localparam int NOTE_AW       = $clog2(NOTE_DEPTH);
	localparam int WAVE_AW       = $clog2(WAVE_DEPTH);
	localparam int PITCH_BITS    = 13;
	localparam int SAMPLE_BITS   = 16;
	localparam int COUNT_BITS    = 9;
	localparam int FIRST_BITS    = 8;
	localparam int NOTE_WORD     = PITCH_BITS + DURATION_BITS;

	localparam logic [1:0] OP_TICK      = 2'd0;
	localparam logic [1:0] OP_START     = 2'd1;
	localparam logic [1:0] OP_LOAD_NOTE = 2'd2;
	localparam logic [1:0] OP_LOAD_WAVE = 2'd3;

	localparam logic [1:0] REG_T0_FIRST = 2'd0;
	localparam logic [1:0] REG_T0_COUNT = 2'd1;
	localparam logic [1:0] REG_T1_FIRST = 2'd2;
	localparam logic [1:0] REG_T1_COUNT = 2'd3;

	typedef logic [NOTE_AW-1:0] note_addr_t;
	typedef logic [WAVE_AW-1:0] wave_addr_t;

	typedef struct packed {
		logic                      we;
		note_addr_t                waddr;
		logic [NOTE_WORD-1:0]      wdata;
		logic                      re;
		note_addr_t                raddr;
	} note_port_t;

	typedef struct packed {
		logic                      we;
		wave_addr_t                waddr;
		logic [SAMPLE_BITS-1:0]    wdata;
		logic                      re;
		wave_addr_t                raddr;
	} wave_port_t;

endpackage

### src/nswt_ram.sv
// Generic single-write, single-read memory with registered read data.
// A read of the address written in the same cycle returns the new word.
// No dependencies.
module nswt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata <= wdata;
			end else begin
				rdata <= mem[raddr];
			end
		end
	end

endmodule

### src/nswt_ctrl.sv
// Input register, playback state update and result register of the tone block.
// Drives the note and waveform memory ports; depends on nswt_pkg.
module nswt_ctrl (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [1:0]                         op,
	input  logic                               track,
	input  logic [7:0]                         note_slot,
	input  logic [12:0]                        pitch_period,
	input  logic [nswt_pkg::DURATION_BITS-1:0] note_duration,
	input  logic [5:0]                         wave_slot,
	input  logic [15:0]                        wave_sample,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               sample_valid,
	output logic [15:0]                        sample,
	output logic                               finished,
	input  logic                               cfg_write_en,
	input  logic [1:0]                         cfg_index,
	input  logic [8:0]                         cfg_data,
	output nswt_pkg::note_port_t               note_port,
	output nswt_pkg::wave_port_t               wave_port,
	input  logic [nswt_pkg::NOTE_WORD-1:0]     note_rdata,
	input  logic [nswt_pkg::SAMPLE_BITS-1:0]   wave_rdata
);
	import nswt_pkg::*;

	logic [FIRST_BITS-1:0] t0_first_q, t1_first_q;
	logic [COUNT_BITS-1:0] t0_count_q, t1_count_q;

	logic                     valid_s1;
	logic [1:0]               op_s1;
	logic                     track_s1;
	note_addr_t               note_slot_s1;
	logic [PITCH_BITS-1:0]    pitch_s1;
	logic [DURATION_BITS-1:0] dur_s1;
	wave_addr_t               wave_slot_s1;
	logic [SAMPLE_BITS-1:0]   wave_sample_s1;

	note_addr_t               pos_q, pos_d;
	logic [COUNT_BITS-1:0]    left_q, left_d;
	logic [DURATION_BITS-1:0] dur_q, dur_d;
	logic [PITCH_BITS-1:0]    per_q, per_d;
	logic [PITCH_BITS-1:0]    pl_q, pl_d;
	wave_addr_t               widx_q, widx_d;
	logic                     playing_q, playing_d;

	logic                     res_valid_q;
	logic                     smp_valid_q, fin_q;
	logic [SAMPLE_BITS-1:0]   smp_q;

	logic                     out_free, adv, accept;
	logic                     emit, fin, smp_valid;
	logic [SAMPLE_BITS-1:0]   smp;
	logic [FIRST_BITS-1:0]    first_s1, first_in;
	logic [COUNT_BITS-1:0]    count_s1;
	logic [PITCH_BITS-1:0]    rd_pitch;
	logic [DURATION_BITS-1:0] rd_dur;

	assign out_free   = !res_valid_q || !result_stall;
	assign adv        = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign accept     = item_valid && !item_stall;

	assign rd_pitch = note_rdata[NOTE_WORD-1:DURATION_BITS];
	assign rd_dur   = note_rdata[DURATION_BITS-1:0];
	assign first_s1 = track_s1 ? t1_first_q : t0_first_q;
	assign count_s1 = track_s1 ? t1_count_q : t0_count_q;
	assign first_in = track ? t1_first_q : t0_first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t0_first_q <= '0;
			t0_count_q <= COUNT_BITS'(52);
			t1_first_q <= FIRST_BITS'(52);
			t1_count_q <= COUNT_BITS'(80);
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_T0_FIRST: t0_first_q <= cfg_data[FIRST_BITS-1:0];
				REG_T0_COUNT: t0_count_q <= cfg_data;
				REG_T1_FIRST: t1_first_q <= cfg_data[FIRST_BITS-1:0];
				REG_T1_COUNT: t1_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1          <= op;
			track_s1       <= track;
			note_slot_s1   <= note_slot[NOTE_AW-1:0];
			pitch_s1       <= pitch_period;
			dur_s1         <= note_duration;
			wave_slot_s1   <= wave_slot[WAVE_AW-1:0];
			wave_sample_s1 <= wave_sample;
		end
	end

	always_comb begin
		pos_d     = pos_q;
		left_d    = left_q;
		dur_d     = dur_q;
		per_d     = per_q;
		pl_d      = pl_q;
		widx_d    = widx_q;
		playing_d = playing_q;
		smp_valid = 1'b0;
		smp       = '0;
		fin       = 1'b0;
		if (adv) begin
			case (op_s1)
				OP_START: begin
					pos_d  = NOTE_AW'(first_s1);
					left_d = count_s1;
					if (count_s1 == '0) begin
						playing_d = 1'b0;
						dur_d     = '0;
						per_d     = '0;
						pl_d      = '0;
					end else begin
						playing_d = 1'b1;
						dur_d     = rd_dur;
						per_d     = rd_pitch;
						pl_d      = rd_pitch;
					end
				end
				OP_TICK: begin
					if (playing_q) begin
						if (per_q != '0) begin
							if (pl_q == '0) begin
								smp_valid = 1'b1;
								smp       = wave_rdata;
								widx_d    = widx_q + 1'b1;
								pl_d      = per_q;
							end else begin
								pl_d = pl_q - 1'b1;
							end
						end
						if (dur_q == '0) begin
							left_d = left_q - 1'b1;
							pos_d  = pos_q + 1'b1;
							if (left_d == '0) begin
								playing_d = 1'b0;
								fin       = 1'b1;
								per_d     = '0;
								pl_d      = '0;
							end else begin
								dur_d = rd_dur;
								per_d = rd_pitch;
								pl_d  = rd_pitch;
							end
						end else begin
							dur_d = dur_q - 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign emit = smp_valid || fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			left_q    <= '0;
			dur_q     <= '0;
			per_q     <= '0;
			pl_q      <= '0;
			widx_q    <= '0;
			playing_q <= 1'b0;
		end else begin
			pos_q     <= pos_d;
			left_q    <= left_d;
			dur_q     <= dur_d;
			per_q     <= per_d;
			pl_q      <= pl_d;
			widx_q    <= widx_d;
			playing_q <= playing_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			smp_valid_q <= smp_valid;
			smp_q       <= smp;
			fin_q       <= fin;
		end
	end

	assign result_valid = res_valid_q;
	assign sample_valid = smp_valid_q;
	assign sample       = smp_q;
	assign finished     = fin_q;

	always_comb begin
		note_port.we    = adv && (op_s1 == OP_LOAD_NOTE);
		note_port.waddr = note_slot_s1;
		note_port.wdata = {pitch_s1, dur_s1};
		note_port.re    = accept;
		note_port.raddr = (op == OP_START) ? NOTE_AW'(first_in) : pos_d + 1'b1;
		wave_port.we    = adv && (op_s1 == OP_LOAD_WAVE);
		wave_port.waddr = wave_slot_s1;
		wave_port.wdata = wave_sample_s1;
		wave_port.re    = accept;
		wave_port.raddr = widx_d;
	end

endmodule

### src/note_sequencer_wavetable_tone.sv
// Top level of the note sequencer with wavetable tone output.
// Instantiates nswt_ctrl and two nswt_ram memories; depends on nswt_pkg.
//
// Takes one word per clock while item_stall is low: ticks, track starts and memory loads
// all move at full rate. A word is registered on entry; once the result register is free,
// its effect on playback is applied and any sample or finished flag goes to that register.
// As a word enters, the waveform memory is read at the index the state will hold once the
// word ahead is done, the note memory one slot past that position (a start: its first slot),
// and a load in the same cycle is forwarded. Memories come up unwritten, not reset-cleared.
module note_sequencer_wavetable_tone (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [1:0]                         op,
	input  logic                               track,
	input  logic [7:0]                         note_slot,
	input  logic [12:0]                        pitch_period,
	input  logic [nswt_pkg::DURATION_BITS-1:0] note_duration,
	input  logic [5:0]                         wave_slot,
	input  logic [15:0]                        wave_sample,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               sample_valid,
	output logic [15:0]                        sample,
	output logic                               finished,
	input  logic                               cfg_write_en,
	input  logic [1:0]                         cfg_index,
	input  logic [8:0]                         cfg_data
);
	import nswt_pkg::*;

	note_port_t               note_port;
	wave_port_t               wave_port;
	logic [NOTE_WORD-1:0]     note_rdata;
	logic [SAMPLE_BITS-1:0]   wave_rdata;

	nswt_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.op            (op),
		.track         (track),
		.note_slot     (note_slot),
		.pitch_period  (pitch_period),
		.note_duration (note_duration),
		.wave_slot     (wave_slot),
		.wave_sample   (wave_sample),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.sample_valid  (sample_valid),
		.sample        (sample),
		.finished      (finished),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.note_port     (note_port),
		.wave_port     (wave_port),
		.note_rdata    (note_rdata),
		.wave_rdata    (wave_rdata)
	);

	nswt_ram #(
		.WIDTH (NOTE_WORD),
		.DEPTH (NOTE_DEPTH)
	) u_note_ram (
		.clk   (clk),
		.we    (note_port.we),
		.waddr (note_port.waddr),
		.wdata (note_port.wdata),
		.re    (note_port.re),
		.raddr (note_port.raddr),
		.rdata (note_rdata)
	);

	nswt_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (WAVE_DEPTH)
	) u_wave_ram (
		.clk   (clk),
		.we    (wave_port.we),
		.waddr (wave_port.waddr),
		.wdata (wave_port.wdata),
		.re    (wave_port.re),
		.raddr (wave_port.raddr),
		.rdata (wave_rdata)
	);

endmodule
